// ===== hw/rtl/chi_pkg.sv =====
package chi_pkg;

  localparam int unsigned SeedWidth = 31;
  localparam int unsigned SizeWidth = 11;
  localparam int unsigned KicksWidth = 6;

  typedef enum logic [1:0] {
    CfgSeedFirst  = 2'd0,
    CfgSeedSecond = 2'd1,
    CfgTableSize  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatCleared  = 2'd0,
    StatInserted = 2'd1,
    StatFailed   = 2'd2
  } status_e;

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StClear  = 10'b0000000010,
    StHash   = 10'b0000000100,
    StMulWait = 10'b0000001000,
    StMod    = 10'b0000010000,
    StRead   = 10'b0000100000,
    StSwap   = 10'b0001000000,
    StDone   = 10'b0010000000,
    StFail   = 10'b0100000000,
    StCleared = 10'b1000000000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_key;    // take input key as current key
    logic mul_start;   // register product for current key and table's seed
    logic mod_step;    // one restoring step of the modulo
    logic mod_init;    // clear the remainder, load the shifter from the product
    logic rd;          // read slot of current table
    logic wr;          // write current key and set valid, swap in old key
    logic sel_second;  // table two is addressed
    logic clr_step;    // clear one valid row
    logic clr_init;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic had;         // slot was occupied at read
    logic clr_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/chi_datapath.sv =====
module chi_datapath import chi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [SeedWidth-1:0] seed_first_i,
  input  logic [SeedWidth-1:0] seed_second_i,
  input  logic [SizeWidth-1:0] table_size_i,
  output logic [KEY_WIDTH-1:0] cur_key_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = KEY_WIDTH + SeedWidth;
  localparam int unsigned DW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = (DW > SizeWidth) ? DW : SizeWidth;
  localparam int unsigned CW = $clog2(PW + 1);

  // effective modulus, clamped to 1..TABLE_DEPTH
  logic [MW-1:0] size_ext, mod_val;
  assign size_ext = MW'(table_size_i);
  always_comb begin
    if (size_ext == '0) mod_val = MW'(1);
    else if (size_ext > MW'(TABLE_DEPTH)) mod_val = MW'(TABLE_DEPTH);
    else mod_val = size_ext;
  end

  logic [KEY_WIDTH-1:0] cur_q, cur_d;
  logic [PW-1:0] prod_q;
  logic [MW:0] rem_q;
  logic [PW-1:0] sh_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] slot_q;

  assign cur_key_o = cur_q;

  // restoring remainder, one product bit per cycle
  logic [MW:0] rem_sh;
  assign rem_sh = {rem_q[MW-1:0], sh_q[PW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q <= PW'(cur_q) * PW'(cmd_i.sel_second ? seed_second_i : seed_first_i);
    end
    if (cmd_i.mod_init) begin
      rem_q <= '0;
      sh_q  <= prod_q;
    end else if (cmd_i.mod_step) begin
      rem_q <= (rem_sh >= {1'b0, mod_val}) ? rem_sh - {1'b0, mod_val} : rem_sh;
      sh_q  <= {sh_q[PW-2:0], 1'b0};
    end
    if (cmd_i.rd) slot_q <= rem_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mod_init) begin
      cnt_q <= CW'(PW);
    end else if (cmd_i.mod_step && cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign stat_o.mod_done = (cnt_q == '0);

  // key stores and valid bits; valid bits drop one row per cycle
  logic [KEY_WIDTH-1:0] keys1 [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] keys2 [TABLE_DEPTH];
  logic vld1 [TABLE_DEPTH];
  logic vld2 [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd1_q, rd2_q;
  logic had_q;
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd1_q <= keys1[rem_q[AW-1:0]];
      rd2_q <= keys2[rem_q[AW-1:0]];
      had_q <= cmd_i.sel_second ? vld2[rem_q[AW-1:0]] : vld1[rem_q[AW-1:0]];
    end
    if (cmd_i.wr && !cmd_i.sel_second) begin
      keys1[slot_q] <= cur_q;
      vld1[slot_q]  <= 1'b1;
    end
    if (cmd_i.wr && cmd_i.sel_second) begin
      keys2[slot_q] <= cur_q;
      vld2[slot_q]  <= 1'b1;
    end
    if (cmd_i.clr_step) begin
      vld1[clr_q] <= 1'b0;
      vld2[clr_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign stat_o.had = had_q;
  assign stat_o.clr_done = (clr_q == AW'(TABLE_DEPTH - 1));

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.load_key) cur_d = key_i;
    else if (cmd_i.wr) cur_d = cmd_i.sel_second ? rd2_q : rd1_q;
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ===== hw/rtl/chi_ctrl.sv =====
module chi_ctrl import chi_pkg::*; #(
  parameter int unsigned MAX_KICKS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  mode_i,
  output logic                  busy_o,
  output dp_cmd_t               cmd_o,
  input  dp_stat_t              stat_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic                  fail_o,
  output logic [KicksWidth-1:0] kicks_o
);

  localparam int unsigned RW = $clog2(MAX_KICKS + 1);

  state_e state_q, state_d;
  logic   sec_q, sec_d;
  logic   boot_q, boot_d;
  logic [RW-1:0] rnd_q, rnd_d;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    rnd_d   = rnd_q;
    boot_d  = boot_q;
    cmd_o   = '0;
    cmd_o.sel_second = sec_q;
    done_o  = 1'b0;
    status_o = StatInserted;
    fail_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (!mode_i) begin
            cmd_o.clr_init = 1'b1;
            state_d = StClear;
          end else begin
            cmd_o.load_key = 1'b1;
            sec_d = 1'b0;
            rnd_d = '0;
            state_d = StHash;
          end
        end
      end
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          // the pass after reset gives no result
          boot_d = 1'b0;
          state_d = boot_q ? StIdle : StCleared;
        end
      end
      StCleared: begin
        done_o = 1'b1;
        status_o = StatCleared;
        state_d = StIdle;
      end
      StHash: begin
        cmd_o.mul_start = 1'b1;
        state_d = StMulWait;
      end
      StMulWait: begin
        cmd_o.mod_init = 1'b1;
        state_d = StMod;
      end
      StMod: begin
        if (stat_i.mod_done) begin
          cmd_o.rd = 1'b1;
          state_d = StRead;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      StRead: begin
        state_d = StSwap;
      end
      StSwap: begin
        cmd_o.wr = 1'b1;
        if (!stat_i.had) begin
          state_d = StDone;
        end else if (sec_q) begin
          sec_d = 1'b0;
          rnd_d = rnd_q + RW'(1);
          state_d = (rnd_q + RW'(1) == RW'(MAX_KICKS)) ? StFail : StHash;
        end else begin
          sec_d = 1'b1;
          state_d = StHash;
        end
      end
      StDone: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      StFail: begin
        done_o = 1'b1;
        status_o = StatFailed;
        fail_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign kicks_o = (state_q == StCleared) ? '0 : KicksWidth'(rnd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sec_q   <= 1'b0;
      boot_q  <= 1'b1;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      boot_q  <= boot_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

// ===== hw/rtl/cuckoo_hash_insert.sv =====
// channel  | signals                              | transfer
// ---------+--------------------------------------+---------------------------
// input    | start_i mode_i key_i / busy_o        | start_i && !busy_o
// result   | done_o status_o dropped_key_o kicks_o| done_o, one cycle
// config   | cfg_valid_i cfg_index_i cfg_data_i   | cfg_valid_i && cfg_ready_o
//
// A clear runs a pass over the valid bits, one row per cycle, then shows its
// result in the next cycle.
// An insert takes up to 2*MAX_KICKS placement steps, each a multiply by the
// seed, a bit-serial modulo by table_size, a read and a swap, then its result.
// Reset loads seeds 1, 1 and table size 1024, then runs the same clearing
// pass with busy_o high and no result.
// The result receiver cannot stall; busy_o holds off the next item.
module cuckoo_hash_insert import chi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_KICKS = 32,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  mode_i,
  input  logic [31:0]           key_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [31:0]           dropped_key_o,
  output logic [KicksWidth-1:0] kicks_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  logic [SeedWidth-1:0] seed1_q, seed2_q;
  logic [SizeWidth-1:0] size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed1_q <= SeedWidth'(1);
      seed2_q <= SeedWidth'(1);
      size_q  <= SizeWidth'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSeedFirst:  seed1_q <= cfg_data_i[SeedWidth-1:0];
        CfgSeedSecond: seed2_q <= cfg_data_i[SeedWidth-1:0];
        CfgTableSize:  size_q  <= cfg_data_i[SizeWidth-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic fail;
  logic [KEY_WIDTH-1:0] cur_key;

  chi_ctrl #(.MAX_KICKS(MAX_KICKS)) u_ctrl (
    .clk_i, .rst_ni, .start_i, .mode_i, .busy_o,
    .cmd_o(cmd), .stat_i(stat), .done_o, .status_o, .fail_o(fail), .kicks_o
  );

  chi_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .key_i(key_i[KEY_WIDTH-1:0]),
    .seed_first_i(seed1_q), .seed_second_i(seed2_q), .table_size_i(size_q),
    .cur_key_o(cur_key)
  );

  assign dropped_key_o = fail ? 32'(cur_key) : '0;

endmodule

// ===== hw/rtl/chi_checker.sv =====
module chi_checker import chi_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [31:0] dropped_key_o
);

  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result without busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item not busy");
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after result");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StatFailed) |-> dropped_key_o == '0)
    else $error("dropped key without failure");

endmodule

bind cuckoo_hash_insert chi_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .dropped_key_o
);

// ===== tb/cuckoo_hash_insert_tb.sv =====
`timescale 1ns / 1ps

module cuckoo_hash_insert_tb;
  import chi_pkg::*;

  localparam int unsigned Depth = 1024;
  localparam int unsigned MaxKicks = 32;
  localparam int unsigned CycleLimit = 20000000;

  typedef struct packed {
    status_e     status;
    logic [31:0] dropped;
    logic [5:0]  kicks;
  } insert_outcome_t;

  class cuckoo_scoreboard;
    logic [31:0] first_keys[Depth];
    bit          first_valid[Depth];
    logic [31:0] second_keys[Depth];
    bit          second_valid[Depth];
    logic [30:0] seed_one;
    logic [30:0] seed_two;
    logic [10:0] size_reg;
    insert_outcome_t pending[$];
    int errors;
    int n_inserted;
    int n_failed;
    int n_cleared;

    function new();
      seed_one = 31'd1;
      seed_two = 31'd1;
      size_reg = 11'd1024;
      foreach (first_valid[i]) begin
        first_valid[i] = 0;
        second_valid[i] = 0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CfgSeedFirst: seed_one = data[30:0];
        CfgSeedSecond: seed_two = data[30:0];
        CfgTableSize: size_reg = data[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned slot_of(logic [31:0] k, logic [30:0] seed);
      logic [63:0] ts;
      ts = (size_reg == 0) ? 64'd1 : (size_reg > Depth) ? 64'(Depth) : 64'(size_reg);
      return int'((64'(k) * 64'(seed)) % ts);
    endfunction

    function void note_input(bit mode, logic [31:0] key);
      insert_outcome_t o;
      logic [31:0] cur;
      logic [31:0] old;
      int unsigned s;
      int unsigned rounds;
      bit had;
      o.status = StatFailed;
      o.dropped = '0;
      rounds = 0;
      if (!mode) begin
        foreach (first_valid[i]) begin
          first_valid[i] = 0;
          second_valid[i] = 0;
        end
        o.status = StatCleared;
        o.kicks = '0;
        pending.push_back(o);
        return;
      end
      cur = key;
      while (rounds < MaxKicks) begin
        s = slot_of(cur, seed_one);
        had = first_valid[s];
        old = first_keys[s];
        first_keys[s] = cur;
        first_valid[s] = 1;
        if (!had) begin
          o.status = StatInserted;
          break;
        end
        cur = old;
        s = slot_of(cur, seed_two);
        had = second_valid[s];
        old = second_keys[s];
        second_keys[s] = cur;
        second_valid[s] = 1;
        if (!had) begin
          o.status = StatInserted;
          break;
        end
        cur = old;
        rounds++;
      end
      if (o.status == StatFailed) o.dropped = cur;
      o.kicks = rounds[5:0];
      pending.push_back(o);
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] dropped, logic [5:0] kicks);
      insert_outcome_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result status=%0d dropped=%h kicks=%0d",
                   status, dropped, kicks);
        return;
      end
      e = pending.pop_front();
      if (status != e.status || dropped != e.dropped || kicks != e.kicks) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected status=%0d dropped=%h kicks=%0d, got %0d %h %0d",
                   e.status, e.dropped, e.kicks, status, dropped, kicks);
      end
      case (e.status)
        StatCleared: n_cleared++;
        StatInserted: n_inserted++;
        default: n_failed++;
      endcase
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        mode;
  logic [31:0] key;
  logic        done;
  logic [1:0]  status;
  logic [31:0] dropped_key;
  logic [KicksWidth-1:0] kicks;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cuckoo_scoreboard sb;
  int unsigned cycles;
  int items_sent;
  bit no_gaps;

  cuckoo_hash_insert dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .mode_i        (mode),
    .key_i         (key),
    .done_o        (done),
    .status_o      (status),
    .dropped_key_o (dropped_key),
    .kicks_o       (kicks),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL cuckoo_hash_insert");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(status, dropped_key, kicks);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold start until the transfer, then idle for a random gap.
  task automatic send_item(bit m, logic [31:0] k);
    int unsigned gap;
    @(negedge clk);
    start = 1'b1;
    mode = m;
    key = k;
    do @(posedge clk); while (busy);
    sb.note_input(m, k);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      mode = $urandom_range(0, 1);
      key = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = $urandom;
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 16);
    if (r < 75) return $urandom_range(17, 256);
    if (r < 85) return 1024;
    if (r < 90) return 0;
    if (r < 95) return $urandom_range(1025, 2047) | ($urandom & 32'hFFFF_F800);
    return $urandom_range(257, 1023);
  endfunction

  function automatic logic [31:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r < 5) return $urandom_range(1, 7);
    return $urandom;
  endfunction

  initial begin
    int unsigned sz;
    int unsigned n;
    logic [31:0] base;
    sb = new();
    cycles = 0;
    items_sent = 0;
    no_gaps = 0;
    rst_n = 1'b0;
    start = 1'b0;
    mode = 1'b0;
    key = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgSeedFirst;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: extremes of the key, collisions, duplicate, clear.
    send_item(1'b1, 32'h0000_0000);
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'd5);
    send_item(1'b1, 32'd1029);
    send_item(1'b1, 32'd2053);
    send_item(1'b1, 32'd5);
    send_item(1'b0, 32'hA5A5_A5A5);
    drain();
    // One-slot tables: the third key fails after the full kick budget.
    write_reg(CfgTableSize, 32'd1);
    send_item(1'b1, 32'h1234_5678);
    send_item(1'b1, 32'h8765_4321);
    send_item(1'b1, 32'hDEAD_BEEF);
    send_item(1'b1, 32'h0000_0001);
    drain();
    // Size zero acts as one; seeds at their extremes.
    write_reg(CfgSeedFirst, 32'hFFFF_FFFF);
    write_reg(CfgSeedSecond, 32'h0);
    write_reg(CfgTableSize, 32'h0);
    send_item(1'b0, 32'h0);
    send_item(1'b1, 32'h7FFF_FFFF);
    send_item(1'b1, 32'h8000_0000);
    send_item(1'b1, 32'h5555_5555);
    drain();
    // Oversized table acts as the full depth.
    write_reg(CfgTableSize, 32'h7FF);
    write_reg(CfgSeedSecond, 32'h7FFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FBFF);
    send_item(1'b1, 32'h0000_0400);
    send_item(1'b1, 32'hAAAA_AAAA);
    drain();

    while (items_sent < 800) begin
      drain();
      write_reg(CfgSeedFirst, pick_seed());
      write_reg(CfgSeedSecond, pick_seed());
      write_reg(CfgTableSize, pick_size());
      no_gaps = ($urandom_range(0, 3) == 0);
      sz = (sb.size_reg == 0) ? 1 : (sb.size_reg > Depth) ? Depth : sb.size_reg;
      n = $urandom_range(1, (sz * 2 + 3 < 30) ? sz * 2 + 3 : 30);
      base = $urandom;
      send_item(1'b0, $urandom);
      repeat (n) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) send_item(1'b0, $urandom);
        else if (r < 40) send_item(1'b1, base + sz * $urandom_range(0, 15));
        else send_item(1'b1, $urandom);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d items: %0d inserted, %0d failed, %0d cleared.",
             items_sent, sb.n_inserted, sb.n_failed, sb.n_cleared);
    $display("Table sizes from zero to oversized, seeds from zero to full scale.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS cuckoo_hash_insert");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("FAIL cuckoo_hash_insert");
    end
    $finish;
  end

endmodule
